/* hdl/sapd_pkg.sv */
package sapd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_BITS = 5;
  localparam logic [31:0] CORDIC_INV_GAIN = 32'd652032874;

  localparam logic [2:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] CFG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] CFG_FREQ_LIMIT    = 3'd2;
  localparam logic [2:0] CFG_FADE_ENABLE   = 3'd3;
  localparam logic [2:0] CFG_DC_ALPHA      = 3'd4;
  localparam logic [2:0] CFG_CARRIER_ALPHA = 3'd5;

  function automatic logic [31:0] turn_atan(input logic [STEP_BITS-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

/* hdl/sapd_serial_mul.sv */
module sapd_serial_mul #(
  parameter int AW = 48,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic        [BW-1:0] b,
  output logic                 busy,
  output logic signed [AW+BW-1:0] p
);
  // unsigned multiplier consumed two bits a cycle, LSB first
  localparam int CW = $clog2(BW / 2 + 2);
  localparam int PW = AW + BW;

  logic signed [PW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] mcd_r, mcd_nxt;
  logic [BW-1:0] mlr_r, mlr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcd_nxt = mcd_r;
    mlr_nxt = mlr_r;
    cnt_nxt = cnt_r;
    if (start) begin
      acc_nxt = '0;
      mcd_nxt = PW'(a);
      mlr_nxt = b;
      cnt_nxt = CW'((BW + 1) / 2);
    end else if (cnt_r != '0) begin
      acc_nxt = acc_r + (mlr_r[0] ? mcd_r : '0) + (mlr_r[1] ? (mcd_r <<< 1) : '0);
      mcd_nxt = mcd_r <<< 2;
      mlr_nxt = mlr_r >> 2;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcd_r <= mcd_nxt;
    mlr_r <= mlr_nxt;
  end

  assign busy = (cnt_r != '0) || start;
  assign p = acc_r;
endmodule

/* hdl/synchronous_am_pll_demodulator_top.sv */
// Synchronous AM detector with a carrier-tracking PLL.
// Input channel: in_valid/in_ready with in_i_sample, in_q_sample. One request
// yields exactly one result on out_valid/out_ready carrying out_audio_out,
// out_carrier_freq and out_phase_error.
// Config channel: cfg_valid/cfg_ready, cfg_index selects the register
// (0 prop_gain .. 5 carrier_alpha), cfg_data holds the value; other indexes
// are ignored. cfg_ready is always high; write only while idle.
// One request is processed at a time. A rotation CORDIC, the I/Q mixing
// products, a vectoring CORDIC with its set-up and the loop and leveller
// products run in turn; all the products go through one radix-4 serial
// multiplier. Each of the eight products (six with the leveller off) is a
// load, 16 two-bit steps and collection. in_ready returns the cycle after
// the result is taken, so a new request is accepted only once the last
// result has been taken. The result sits in an output register; a stalled
// receiver holds it and in_ready stays low until it is taken. Reset (rst_n,
// synchronous) clears NCO phase, loop state, trackers and restores register
// defaults.
module synchronous_am_pll_demodulator_top #(
  parameter int PHASE_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_i_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_q_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_BITS+1:0] out_audio_out,
  output logic signed [23:0]           out_carrier_freq,
  output logic signed [15:0]           out_phase_error,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [23:0]                  cfg_data
);
  import sapd_pkg::*;

  localparam int AB = SAMPLE_BITS + 2;
  localparam int TF = 32 - AB;
  localparam int MAW = 64;
  localparam int MBW = 32;
  localparam int RW = SAMPLE_BITS + 4;
  localparam int VW = RW + 18;

  localparam logic [3:0] S_IDLE = 4'd0, S_ROT = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
    S_M3 = 4'd4, S_M4 = 4'd5, S_DC = 4'd6, S_CA = 4'd7, S_VEC = 4'd8,
    S_IG = 4'd9, S_PG = 4'd10, S_FIN = 4'd11, S_OUT = 4'd12;

  logic [23:0] prop_gain_r, integ_gain_r;
  logic [22:0] freq_limit_r;
  logic        fade_enable_r;
  logic [15:0] dc_alpha_r, carrier_alpha_r;

  logic [PHASE_BITS-1:0] nco_phase_r, nco_phase_nxt;
  logic signed [PHASE_BITS-1:0] freq_int_r, freq_int_nxt;
  logic signed [PHASE_BITS:0] prev_fo_r, prev_fo_nxt;
  logic signed [31:0] dc_track_r, dc_track_nxt, car_track_r, car_track_nxt;

  logic [3:0] state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic signed [SAMPLE_BITS-1:0] si_r, sq_r;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [32:0] cz_r, cz_nxt;
  logic flip_r, flip_nxt;
  logic signed [MAW+MBW-1:0] pa_r, pa_nxt;
  logic signed [RW-1:0] re_r, re_nxt, im_r, im_nxt;
  logic signed [VW-1:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic [31:0] vz_r, vz_nxt;
  logic zero_r, zero_nxt;
  logic signed [AB+1:0] audio_r, audio_nxt;
  logic signed [AB-1:0] aout_r, aout_nxt;
  logic signed [15:0] perr_r, perr_nxt;
  logic signed [PHASE_BITS-1:0] det_r, det_nxt;

  logic mstart;
  logic signed [MAW-1:0] ma;
  logic [MBW-1:0] mb;
  logic mbusy, mstarted_r, mstarted_nxt;
  logic signed [MAW+MBW-1:0] mp;

  sapd_serial_mul #(.AW(MAW), .BW(MBW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .busy(mbusy), .p(mp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_audio_out = aout_r;
  assign out_carrier_freq = 24'(freq_int_r);
  assign out_phase_error = perr_r;

  logic [31:0] ph32;
  logic signed [63:0] lim, cap, fi_w, pf_w;
  logic signed [63:0] trk;
  logic [31:0] zr;
  logic mdone;

  assign mdone = mstarted_r && !mbusy;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; flip_nxt = flip_r;
    pa_nxt = pa_r; re_nxt = re_r; im_nxt = im_r;
    vx_nxt = vx_r; vy_nxt = vy_r; vz_nxt = vz_r; zero_nxt = zero_r;
    audio_nxt = audio_r; aout_nxt = aout_r; perr_nxt = perr_r; det_nxt = det_r;
    nco_phase_nxt = nco_phase_r; freq_int_nxt = freq_int_r; prev_fo_nxt = prev_fo_r;
    dc_track_nxt = dc_track_r; car_track_nxt = car_track_r;
    mstart = 1'b0; ma = '0; mb = '0;
    mstarted_nxt = mstarted_r;
    ph32 = '0; lim = '0; fi_w = '0; pf_w = '0; trk = '0; zr = '0;
    cap = (64'sd1 <<< (PHASE_BITS - 1)) - 64'sd1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ph32 = 32'({nco_phase_r, 32'd0} >> PHASE_BITS);
          flip_nxt = ph32[31] ^ ph32[30];
          cz_nxt = 33'(signed'(ph32 ^ {ph32[31] ^ ph32[30], 31'd0}));
          cx_nxt = 34'(CORDIC_INV_GAIN);
          cy_nxt = '0;
          step_nxt = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (cz_r >= 0) begin
          cx_nxt = cx_r - (cy_r >>> step_r);
          cy_nxt = cy_r + (cx_r >>> step_r);
          cz_nxt = cz_r - 33'(turn_atan(step_r));
        end else begin
          cx_nxt = cx_r + (cy_r >>> step_r);
          cy_nxt = cy_r - (cx_r >>> step_r);
          cz_nxt = cz_r + 33'(turn_atan(step_r));
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(CORDIC_STEPS - 1)) begin
          if (flip_r) begin
            cx_nxt = -cx_nxt;
            cy_nxt = -cy_nxt;
          end
          state_nxt = S_M1;
          mstarted_nxt = 1'b0;
        end
      end
      S_M1, S_M2, S_M3, S_M4: begin
        // products of sample and |c|,|s| with sign applied after
        if (!mstarted_r) begin
          mstart = 1'b1;
          mstarted_nxt = 1'b1;
          case (state_r)
            S_M1: begin ma = MAW'(si_r); mb = MBW'(cx_r < 0 ? -cx_r : cx_r); end
            S_M2: begin ma = MAW'(sq_r); mb = MBW'(cy_r < 0 ? -cy_r : cy_r); end
            S_M3: begin ma = MAW'(sq_r); mb = MBW'(cx_r < 0 ? -cx_r : cx_r); end
            default: begin ma = MAW'(si_r); mb = MBW'(cy_r < 0 ? -cy_r : cy_r); end
          endcase
        end else if (mdone) begin
          mstarted_nxt = 1'b0;
          case (state_r)
            S_M1: begin
              pa_nxt = (cx_r < 0) ? -mp : mp;
              state_nxt = S_M2;
            end
            S_M2: begin
              re_nxt = RW'((pa_r + ((cy_r < 0) ? -mp : mp)) >>> 30);
              state_nxt = S_M3;
            end
            S_M3: begin
              pa_nxt = (cx_r < 0) ? -mp : mp;
              state_nxt = S_M4;
            end
            default: begin
              im_nxt = RW'((pa_r - ((cy_r < 0) ? -mp : mp)) >>> 30);
              audio_nxt = (AB + 2)'(re_r) + (AB + 2)'(RW'((pa_r - ((cy_r < 0) ? -mp : mp)) >>> 30));
              state_nxt = fade_enable_r ? S_DC : S_VEC;
              if (!fade_enable_r) step_nxt = '1;
            end
          endcase
        end
      end
      S_DC: begin
        trk = (64'(audio_r) <<< TF) - 64'(dc_track_r);
        if (!mstarted_r) begin
          mstart = 1'b1; mstarted_nxt = 1'b1;
          ma = MAW'(trk); mb = MBW'(dc_alpha_r);
        end else if (mdone) begin
          mstarted_nxt = 1'b0;
          dc_track_nxt = 32'(64'(dc_track_r) + 64'(mp >>> 16));
          state_nxt = S_CA;
        end
      end
      S_CA: begin
        trk = (64'(re_r) <<< TF) - 64'(car_track_r);
        if (!mstarted_r) begin
          mstart = 1'b1; mstarted_nxt = 1'b1;
          ma = MAW'(trk); mb = MBW'(carrier_alpha_r);
        end else if (mdone) begin
          mstarted_nxt = 1'b0;
          car_track_nxt = 32'(64'(car_track_r) + 64'(mp >>> 16));
          audio_nxt = audio_r + (AB + 2)'((64'(32'(64'(car_track_r) + 64'(mp >>> 16)))
                      - 64'(dc_track_r)) >>> TF);
          state_nxt = S_VEC;
          step_nxt = '1;
        end
      end
      S_VEC: begin
        if (step_r == '1) begin
          // setup: fold into right half plane
          zero_nxt = (re_r == 0) && (im_r == 0);
          if (re_r < 0) begin
            vx_nxt = -(VW'(re_r) <<< 16); vy_nxt = -(VW'(im_r) <<< 16);
            vz_nxt = 32'h80000000;
          end else begin
            vx_nxt = VW'(re_r) <<< 16; vy_nxt = VW'(im_r) <<< 16;
            vz_nxt = '0;
          end
          step_nxt = '0;
          if (audio_r > (AB + 2)'((1 <<< (AB - 1)) - 1)) aout_nxt = AB'((1 <<< (AB - 1)) - 1);
          else if (audio_r < -(AB + 2)'(1 <<< (AB - 1))) aout_nxt = AB'(-(1 <<< (AB - 1)));
          else aout_nxt = AB'(audio_r);
        end else begin
          if (vy_r < 0) begin
            vx_nxt = vx_r - (vy_r >>> step_r);
            vy_nxt = vy_r + (vx_r >>> step_r);
            vz_nxt = vz_r - turn_atan(step_r);
          end else begin
            vx_nxt = vx_r + (vy_r >>> step_r);
            vy_nxt = vy_r - (vx_r >>> step_r);
            vz_nxt = vz_r + turn_atan(step_r);
          end
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_BITS'(CORDIC_STEPS - 1)) begin
            zr = zero_r ? 32'd0 : vz_nxt;
            vz_nxt = zr;
            perr_nxt = 16'((zr + 32'h8000) >> 16);
            det_nxt = PHASE_BITS'(signed'(zr) >>> (32 - PHASE_BITS));
            state_nxt = S_IG;
            mstarted_nxt = 1'b0;
          end
        end
      end
      S_IG: begin
        if (!mstarted_r) begin
          mstart = 1'b1; mstarted_nxt = 1'b1;
          ma = MAW'(det_r); mb = MBW'(integ_gain_r);
        end else if (mdone) begin
          mstarted_nxt = 1'b0;
          lim = 64'(freq_limit_r);
          if (lim > cap) lim = cap;
          fi_w = 64'(freq_int_r) + 64'(mp >>> 24);
          if (fi_w < -lim) fi_w = -lim;
          else if (fi_w > lim) fi_w = lim;
          freq_int_nxt = PHASE_BITS'(fi_w);
          state_nxt = S_PG;
        end
      end
      S_PG: begin
        if (!mstarted_r) begin
          mstart = 1'b1; mstarted_nxt = 1'b1;
          ma = MAW'(det_r); mb = MBW'(prop_gain_r);
        end else if (mdone) begin
          mstarted_nxt = 1'b0;
          pf_w = 64'(mp >>> 24) + 64'(freq_int_r);
          prev_fo_nxt = (PHASE_BITS + 1)'(pf_w);
          nco_phase_nxt = nco_phase_r + PHASE_BITS'(prev_fo_r);
          state_nxt = S_FIN;
        end
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mstarted_r <= 1'b0;
      step_r <= '0;
      nco_phase_r <= '0;
      freq_int_r <= '0;
      prev_fo_r <= '0;
      dc_track_r <= '0;
      car_track_r <= '0;
      prop_gain_r <= 24'd131072;
      integ_gain_r <= 24'd2048;
      freq_limit_r <= 23'd699051;
      fade_enable_r <= 1'b1;
      dc_alpha_r <= 16'd131;
      carrier_alpha_r <= 16'd2;
    end else begin
      state_r <= state_nxt;
      mstarted_r <= mstarted_nxt;
      step_r <= step_nxt;
      nco_phase_r <= nco_phase_nxt;
      freq_int_r <= freq_int_nxt;
      prev_fo_r <= prev_fo_nxt;
      dc_track_r <= dc_track_nxt;
      car_track_r <= car_track_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PROP_GAIN:     prop_gain_r <= cfg_data;
          CFG_INTEG_GAIN:    integ_gain_r <= cfg_data;
          CFG_FREQ_LIMIT:    freq_limit_r <= cfg_data[22:0];
          CFG_FADE_ENABLE:   fade_enable_r <= cfg_data[0];
          CFG_DC_ALPHA:      dc_alpha_r <= cfg_data[15:0];
          CFG_CARRIER_ALPHA: carrier_alpha_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    if (in_valid && in_ready) begin
      si_r <= in_i_sample;
      sq_r <= in_q_sample;
    end
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; flip_r <= flip_nxt;
    pa_r <= pa_nxt; re_r <= re_nxt; im_r <= im_nxt;
    vx_r <= vx_nxt; vy_r <= vy_nxt; vz_r <= vz_nxt; zero_r <= zero_nxt;
    audio_r <= audio_nxt; aout_r <= aout_nxt; perr_r <= perr_nxt; det_r <= det_nxt;
  end
endmodule

/* tb/sapd_checker.sv */
module sapd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_i_sample,
  input  logic signed [15:0] in_q_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [17:0] out_audio_out,
  input  logic signed [23:0] out_carrier_freq,
  input  logic signed [15:0] out_phase_error,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 checked
);
  import sapd_pkg::*;

  typedef struct {
    logic signed [17:0] audio;
    logic signed [23:0] freq;
    logic signed [15:0] perr;
  } demod_result_t;

  localparam bit [31:0] ARC_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
  localparam longint PHASE_CAP = 64'd8388607;
  localparam int TRACK_SHIFT = 14;

  demod_result_t awaited_results[$];

  longint g_prop, g_integ, f_limit, dc_a, car_a;
  bit lev_on;
  bit [23:0] nco;
  longint f_integ, last_loop_out, dc_lvl, car_lvl;

  function automatic void nco_sin_cos(input bit [31:0] ph, output longint c,
                                      output longint s);
    bit flip;
    longint x, y, z, dx, dy;
    flip = ph[31] ^ ph[30];
    if (flip) ph[31] = ~ph[31];
    x = 64'd652032874;
    y = 0;
    z = longint'(signed'(ph));
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARC_TAB[k]);
      end else begin
        x += dx; y -= dy; z += longint'(ARC_TAB[k]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic bit [31:0] vector_angle(input longint x, input longint y);
    bit [31:0] z;
    longint dx, dy;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    x *= 65536;
    y *= 65536;
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y < 0) begin
        x -= dx; y += dy; z = z - ARC_TAB[k];
      end else begin
        x += dx; y -= dy; z = z + ARC_TAB[k];
      end
    end
    return z;
  endfunction

  function automatic demod_result_t demodulate(input logic signed [15:0] i_s,
                                               input logic signed [15:0] q_s);
    demod_result_t r;
    longint si, sq, c, s, re, im, aud, det, lim, del;
    bit [31:0] z, zr;
    si = i_s;
    sq = q_s;
    nco_sin_cos({nco, 8'h00}, c, s);
    re = (si * c + sq * s) >>> 30;
    im = (sq * c - si * s) >>> 30;
    aud = re + im;
    if (lev_on) begin
      dc_lvl += ((aud * (64'sd1 <<< TRACK_SHIFT) - dc_lvl) * dc_a) >>> 16;
      car_lvl += ((re * (64'sd1 <<< TRACK_SHIFT) - car_lvl) * car_a) >>> 16;
      aud += (car_lvl - dc_lvl) >>> TRACK_SHIFT;
    end
    z = vector_angle(re, im);
    zr = z + 32'h8000;
    det = longint'(signed'(z)) >>> 8;
    del = last_loop_out;
    lim = (f_limit > PHASE_CAP) ? PHASE_CAP : f_limit;
    f_integ += (det * g_integ) >>> 24;
    if (f_integ < -lim) f_integ = -lim;
    else if (f_integ > lim) f_integ = lim;
    last_loop_out = ((det * g_prop) >>> 24) + f_integ;
    nco = nco + del[23:0];
    if (aud > 131071) aud = 131071;
    else if (aud < -131072) aud = -131072;
    r.audio = aud[17:0];
    r.freq = f_integ[23:0];
    r.perr = zr[31:16];
    return r;
  endfunction

  assign pending = awaited_results.size();

  always_ff @(posedge clk) begin
    demod_result_t e;
    if (!rst_n) begin
      g_prop <= 131072; g_integ <= 2048; f_limit <= 699051; lev_on <= 1'b1;
      dc_a <= 131; car_a <= 2;
      nco = '0; f_integ = 0; last_loop_out = 0; dc_lvl = 0; car_lvl = 0;
      awaited_results.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN:     g_prop <= cfg_data;
          CFG_INTEG_GAIN:    g_integ <= cfg_data;
          CFG_FREQ_LIMIT:    f_limit <= cfg_data[22:0];
          CFG_FADE_ENABLE:   lev_on <= cfg_data[0];
          CFG_DC_ALPHA:      dc_a <= cfg_data[15:0];
          CFG_CARRIER_ALPHA: car_a <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited_results.push_back(demodulate(in_i_sample, in_q_sample));
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          errors <= errors + 1;
        end else begin
          e = awaited_results.pop_front();
          if (e.audio !== out_audio_out || e.freq !== out_carrier_freq ||
              e.perr !== out_phase_error) begin
            errors <= errors + 1;
            if (e.audio !== out_audio_out)
              $error("audio_out exp %0d got %0d", e.audio, out_audio_out);
            if (e.freq !== out_carrier_freq)
              $error("carrier_freq exp %0d got %0d", e.freq, out_carrier_freq);
            if (e.perr !== out_phase_error)
              $error("phase_error exp %0d got %0d", e.perr, out_phase_error);
          end
        end
      end
    end
  end
endmodule

/* tb/tb_synchronous_am_pll_demodulator_top.sv */
module tb_synchronous_am_pll_demodulator_top;
  import sapd_pkg::*;

  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam logic [2:0] CFG_RESERVED = 3'd6;
  localparam int STALL_LIMIT = 5000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [15:0] in_i_sample, in_q_sample, out_phase_error;
  logic signed [17:0] out_audio_out;
  logic signed [23:0] out_carrier_freq;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;
  int errors, pending, checked, idle_cycles, phases;
  bit busy_mode;
  real tone_ph;

  synchronous_am_pll_demodulator_top dut (.*);

  sapd_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = busy_mode ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_sample(input logic signed [15:0] i_s, input logic signed [15:0] q_s);
    int gap;
    gap = busy_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_i_sample <= i_s;
    in_q_sample <= q_s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [23:0] pg, input logic [23:0] ig,
                           input logic [23:0] fl, input logic [23:0] fe,
                           input logic [23:0] da, input logic [23:0] ca);
    write_reg(CFG_PROP_GAIN, pg);
    write_reg(CFG_INTEG_GAIN, ig);
    write_reg(CFG_FREQ_LIMIT, fl);
    write_reg(CFG_FADE_ENABLE, fe);
    write_reg(CFG_DC_ALPHA, da);
    write_reg(CFG_CARRIER_ALPHA, ca);
    phases++;
  endtask

  // mostly AM carriers with a frequency offset, some plain noise
  task automatic random_burst(input int n);
    real amp, df, m;
    int mode;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        busy_mode = ($urandom_range(0, 3) == 0);
        mode = $urandom_range(0, 3);
        amp = $urandom_range(100, 32000);
        df = ($urandom_range(0, 2000) - 1000.0) / 20000.0;
      end
      if (mode == 0) begin
        send_sample(16'($urandom), 16'($urandom));
      end else begin
        m = 1.0 + 0.4 * $sin(k * 0.3);
        if (m * amp > 32767.0) m = 32767.0 / amp;
        tone_ph += df;
        send_sample(16'($rtoi(amp * m * $cos(tone_ph))),
                    16'($rtoi(amp * m * $sin(tone_ph))));
      end
    end
  endtask

  initial begin
    in_valid = 1'b0; cfg_valid = 1'b0;
    in_i_sample = '0; in_q_sample = '0; cfg_index = '0; cfg_data = '0;
    busy_mode = 0;
    phases = 1;
    tone_ph = 0.0;
    @(posedge clk iff rst_n);
    @(posedge clk);
    send_sample('0, '0);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(-16'sh8000, '0);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample('0, 16'sh7FFF);
    send_sample('0, -16'sh8000);
    send_sample(16'sh5555, -16'sh5556);
    send_sample(-16'sh5556, 16'sh5555);
    send_sample(-16'sd1, '0);
    send_sample('0, '0);
    random_burst(250);
    drain();
    load_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFF, 24'hFFFFFF);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(-16'sh8000, '0);
    random_burst(250);
    drain();
    load_regs(24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0);
    write_reg(CFG_SPARE, 24'hABCDEF);
    write_reg(CFG_RESERVED, 24'h123456);
    random_burst(150);
    drain();
    load_regs(24'h7FFFFF, 24'h100000, 24'h000400, 24'd1, 24'h00FFFF, 24'h00FFFF);
    random_burst(150);
    for (int p = 0; p < 4; p++) begin
      drain();
      load_regs(24'($urandom), 24'($urandom >> $urandom_range(0, 20)), 24'($urandom),
                24'($urandom), 24'($urandom), 24'($urandom >> $urandom_range(0, 14)));
      random_burst(150);
    end
    drain();
    repeat (300) @(posedge clk);
    $display("Checked %0d demodulated samples over %0d register settings,", checked, phases);
    $display("with extreme samples, leveller on and off, and loop clamp limits.");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
